// ===== hw/rtl/plmt_pkg.sv =====
// Shared types, constants and helpers of the pair momentum transform unit.
package plmt_pkg;

  localparam int MOMENTUM_WIDTH  = 24;
  localparam int MASS_WIDTH      = 20;
  localparam int MASS_FRACTION   = 16;
  localparam int CFG_INDEX_WIDTH = 8;

  localparam logic [MASS_WIDTH-1:0] MASS_RESET = MASS_WIDTH'(9147);

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_MASS_FIRST  = CFG_INDEX_WIDTH'(0);
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_MASS_SECOND = CFG_INDEX_WIDTH'(1);

  typedef struct packed {
    logic signed [MOMENTUM_WIDTH-1:0] first_px;
    logic signed [MOMENTUM_WIDTH-1:0] first_py;
    logic signed [MOMENTUM_WIDTH-1:0] first_pz;
    logic signed [MOMENTUM_WIDTH-1:0] second_px;
    logic signed [MOMENTUM_WIDTH-1:0] second_py;
    logic signed [MOMENTUM_WIDTH-1:0] second_pz;
  } pair_in_t;

  typedef struct packed {
    logic signed [MOMENTUM_WIDTH-1:0] out_first_px;
    logic signed [MOMENTUM_WIDTH-1:0] out_first_py;
    logic signed [MOMENTUM_WIDTH-1:0] out_first_pz;
    logic signed [MOMENTUM_WIDTH-1:0] out_second_px;
    logic signed [MOMENTUM_WIDTH-1:0] out_second_py;
    logic signed [MOMENTUM_WIDTH-1:0] out_second_pz;
    logic                             transform_failed;
  } pair_out_t;

  // Clamp a rounded quotient magnitude to the signed momentum range and apply its sign.
  function automatic logic [MOMENTUM_WIDTH-1:0] saturate(
    input logic [MOMENTUM_WIDTH-1:0] quot,
    input logic                      neg,
    input logic                      ovf
  );
    logic [MOMENTUM_WIDTH-1:0] limit;
    logic [MOMENTUM_WIDTH-1:0] mag;
    limit = neg ? {1'b1, {(MOMENTUM_WIDTH-1){1'b0}}} : {1'b0, {(MOMENTUM_WIDTH-1){1'b1}}};
    mag   = (ovf || quot > limit) ? limit : quot;
    return neg ? MOMENTUM_WIDTH'(-mag) : mag;
  endfunction

endpackage

// ===== hw/rtl/plmt_sqrt.sv =====
// Pipelined integer square root, one root bit per stage, several lanes sharing one tag.
module plmt_sqrt #(
  parameter int IN_WIDTH  = 50,
  parameter int LANES     = 3,
  parameter int TAG_WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic [IN_WIDTH-1:0]      in_value [LANES],
  input  logic [TAG_WIDTH-1:0]     in_tag,
  output logic                     out_valid,
  output logic [IN_WIDTH/2-1:0]    out_root [LANES],
  output logic [IN_WIDTH/2+1:0]    out_rem  [LANES],
  output logic [TAG_WIDTH-1:0]     out_tag
);

  localparam int H  = IN_WIDTH / 2;
  localparam int RW = H + 2;

  logic                 vld  [H+1];
  logic [TAG_WIDTH-1:0] tag  [H+1];
  logic [IN_WIDTH-1:0]  val  [H][LANES];
  logic [RW-1:0]        rem  [H+1][LANES];
  logic [H-1:0]         root [H+1][LANES];

  // Stage zero is the request itself
  assign vld[0] = in_valid;
  assign tag[0] = in_tag;

  for (genvar l = 0; l < LANES; l++) begin : g_in
    assign val[0][l]  = in_value[l];
    assign rem[0][l]  = '0;
    assign root[0][l] = '0;
  end

  for (genvar k = 1; k <= H; k++) begin : g_stage
    // Advance valid and tag with the data
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else begin
        vld[k] <= vld[k-1];
      end
      tag[k] <= tag[k-1];
    end

    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [RW+1:0] rem_try;
      logic [RW+1:0] trial;
      logic          fits;

      // Bring down the next two bits and try the next root bit
      assign rem_try = {rem[k-1][l], val[k-1][l][IN_WIDTH-1 -: 2]};
      assign trial   = (RW+2)'({root[k-1][l], 2'b01});
      assign fits    = rem_try >= trial;

      always_ff @(posedge clk) begin
        rem[k][l]  <= fits ? RW'(rem_try - trial) : RW'(rem_try);
        root[k][l] <= {root[k-1][l][H-2:0], fits};
      end

      if (k < H) begin : g_shift
        always_ff @(posedge clk) begin
          val[k][l] <= val[k-1][l] << 2;
        end
      end
    end
  end

  // Present the last stage
  for (genvar l = 0; l < LANES; l++) begin : g_out
    assign out_root[l] = root[H][l];
    assign out_rem[l]  = rem[H][l];
  end

  assign out_valid = vld[H];
  assign out_tag   = tag[H];

endmodule

// ===== hw/rtl/plmt_div.sv =====
// Pipelined round-to-nearest signed division, one quotient bit per stage, several lanes.
module plmt_div #(
  parameter int QUOT_WIDTH = 24,
  parameter int NUM_WIDTH  = 53,
  parameter int DEN_WIDTH  = 28,
  parameter int LANES      = 6,
  parameter int TAG_WIDTH  = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic signed [NUM_WIDTH-1:0] in_num [LANES],
  input  logic [DEN_WIDTH-1:0]        in_den [LANES],
  input  logic [TAG_WIDTH-1:0]        in_tag,
  output logic                        out_valid,
  output logic [QUOT_WIDTH-1:0]       out_quot [LANES],
  output logic                        out_neg  [LANES],
  output logic                        out_ovf  [LANES],
  output logic [TAG_WIDTH-1:0]        out_tag
);

  localparam int Q  = QUOT_WIDTH;
  localparam int CW = ((NUM_WIDTH > DEN_WIDTH + Q) ? NUM_WIDTH : DEN_WIDTH + Q) + 2;

  logic                 vld [Q+1];
  logic [TAG_WIDTH-1:0] tag [Q+1];
  logic [CW-1:0]        rem [Q][LANES];
  logic [CW-1:0]        dd  [Q][LANES];
  logic [Q-1:0]         quo [Q+1][LANES];
  logic                 neg [Q+1][LANES];
  logic                 ovf [Q+1][LANES];

  // Entry stage: hold valid and tag
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= in_valid;
    end
    tag[0] <= in_tag;
  end

  for (genvar l = 0; l < LANES; l++) begin : g_entry
    logic [NUM_WIDTH-1:0] mag;
    logic [CW-1:0]        n2;
    logic [CW-1:0]        d2;

    // Round to nearest: floor((2|n| + d) / 2d)
    assign mag = in_num[l][NUM_WIDTH-1] ? NUM_WIDTH'(-in_num[l]) : NUM_WIDTH'(in_num[l]);
    assign n2  = (CW'(mag) << 1) + CW'(in_den[l]);
    assign d2  = CW'(in_den[l]) << 1;

    always_ff @(posedge clk) begin
      rem[0][l] <= n2;
      dd[0][l]  <= d2;
      quo[0][l] <= '0;
      neg[0][l] <= in_num[l][NUM_WIDTH-1];
      ovf[0][l] <= n2 >= (d2 << Q);
    end
  end

  for (genvar j = 1; j <= Q; j++) begin : g_stage
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j] <= 1'b0;
      end else begin
        vld[j] <= vld[j-1];
      end
      tag[j] <= tag[j-1];
    end

    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [CW-1:0] sub;
      logic          fits;

      // Try the divisor at the current quotient bit
      assign sub  = dd[j-1][l] << (Q - j);
      assign fits = rem[j-1][l] >= sub;

      always_ff @(posedge clk) begin
        quo[j][l] <= {quo[j-1][l][Q-2:0], fits};
        neg[j][l] <= neg[j-1][l];
        ovf[j][l] <= ovf[j-1][l];
      end

      if (j < Q) begin : g_carry
        always_ff @(posedge clk) begin
          rem[j][l] <= fits ? rem[j-1][l] - sub : rem[j-1][l];
          dd[j][l]  <= dd[j-1][l];
        end
      end
    end
  end

  // Present the last stage
  for (genvar l = 0; l < LANES; l++) begin : g_out
    assign out_quot[l] = quo[Q][l];
    assign out_neg[l]  = neg[Q][l];
    assign out_ovf[l]  = ovf[Q][l];
  end

  assign out_valid = vld[Q];
  assign out_tag   = tag[Q];

endmodule

// ===== hw/rtl/pair_lcms_momentum_transform_unit.sv =====
// Top level of the pair momentum transform unit: rotation to pair pt along x and LCMS boost.
//
// Takes one particle pair per clock (busy is high only during reset) and returns one result
// per pair, in order, on result with a one-cycle done strobe; the receiver cannot stall it.
// The path holds 3 front stages, one stage per energy/pt root bit (EIN_W/2), 3 product
// stages, one stage per boost root bit (EIN_W/2 + 2), one rounding stage, MOMENTUM_WIDTH + 1
// divider stages and the output register. The two root pipelines and the shared divider
// pipeline make up most of that depth. Masses are written through the cfg port, always ready;
// the user must write them only while no request is in flight; the block does not enforce it.
module pair_lcms_momentum_transform_unit #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  plmt_pkg::pair_in_t                  pair,
  output logic                                done,
  output plmt_pkg::pair_out_t                 result,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [plmt_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [plmt_pkg::MASS_WIDTH-1:0]     cfg_data
);

  import plmt_pkg::*;

  localparam int W      = MOMENTUM_WIDTH;
  localparam int SW     = W + 1;
  localparam int MSW    = MASS_WIDTH + FRACTION_BITS - MASS_FRACTION;
  localparam int SQ_W   = 2 * W;
  localparam int MSQ_W  = 2 * MSW;
  localparam int EIN_W  = ((SQ_W > MSQ_W) ? SQ_W : MSQ_W) + 2;
  localparam int H1     = EIN_W / 2;
  localparam int EBW    = H1 + 1;
  localparam int PTW    = H1 + 1;
  localparam int ETW    = H1 + 2;
  localparam int RSW    = 2 * W + 2;
  localparam int BSW    = ETW + W + 2;
  localparam int LSQ_W  = 2 * ETW;
  localparam int LW     = ETW + 1;
  localparam int PRW    = 2 * W + 1;
  localparam int BPW    = ETW + W + 1;

  typedef struct packed {
    pair_in_t             p;
    logic signed [SW-1:0] sx;
    logic signed [SW-1:0] sy;
    logic signed [SW-1:0] sz;
    logic                 fail;
  } front_t;

  typedef struct packed {
    pair_in_t p;
    logic     fail;
  } tail_t;

  typedef struct packed {
    tail_t                 tl;
    logic [PTW-1:0]        pt;
    logic signed [RSW-1:0] rot_x1;
    logic signed [RSW-1:0] rot_y1;
    logic signed [RSW-1:0] rot_x2;
    logic signed [RSW-1:0] rot_y2;
    logic signed [BSW-1:0] bz1;
    logic signed [BSW-1:0] bz2;
  } mid_t;

  logic [MASS_WIDTH-1:0] mass_first;
  logic [MASS_WIDTH-1:0] mass_second;
  logic [MSW-1:0]        m1_scaled;
  logic [MSW-1:0]        m2_scaled;

  assign busy      = rst;
  assign cfg_ready = 1'b1;

  // Mass registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mass_first  <= MASS_RESET;
      mass_second <= MASS_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_MASS_FIRST:  mass_first  <= cfg_data;
        REG_MASS_SECOND: mass_second <= cfg_data;
        default: ;
      endcase
    end
  end

  // Align masses to the momentum fraction
  if (FRACTION_BITS >= MASS_FRACTION) begin : g_mass_up
    assign m1_scaled = MSW'(mass_first) << (FRACTION_BITS - MASS_FRACTION);
    assign m2_scaled = MSW'(mass_second) << (FRACTION_BITS - MASS_FRACTION);
  end else begin : g_mass_down
    assign m1_scaled = MSW'(mass_first >> (MASS_FRACTION - FRACTION_BITS));
    assign m2_scaled = MSW'(mass_second >> (MASS_FRACTION - FRACTION_BITS));
  end

  function automatic logic [W-1:0] mag_w(input logic signed [W-1:0] v);
    return v[W-1] ? W'(-v) : W'(v);
  endfunction

  function automatic logic [SW-1:0] mag_s(input logic signed [SW-1:0] v);
    return v[SW-1] ? SW'(-v) : SW'(v);
  endfunction

  // ---------------- stage 0: pair sums ----------------
  front_t front_next;
  front_t s0;
  logic   s0_valid;

  always_comb begin
    front_next.p    = pair;
    front_next.sx   = {pair.first_px[W-1], pair.first_px} + {pair.second_px[W-1], pair.second_px};
    front_next.sy   = {pair.first_py[W-1], pair.first_py} + {pair.second_py[W-1], pair.second_py};
    front_next.sz   = {pair.first_pz[W-1], pair.first_pz} + {pair.second_pz[W-1], pair.second_pz};
    front_next.fail = (front_next.sx == '0) && (front_next.sy == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else begin
      s0_valid <= start && !busy;
    end
    s0 <= front_next;
  end

  // ---------------- stage 1: squares ----------------
  front_t            s1;
  logic              s1_valid;
  logic [SQ_W-1:0]   s1_sq [6];
  logic [MSQ_W-1:0]  s1_msq [2];
  logic [2*SW-1:0]   s1_sxsq;
  logic [2*SW-1:0]   s1_sysq;
  logic [W-1:0]      s0_mag [6];
  logic [SW-1:0]     s0_sxm;
  logic [SW-1:0]     s0_sym;

  assign s0_mag[0] = mag_w(s0.p.first_px);
  assign s0_mag[1] = mag_w(s0.p.first_py);
  assign s0_mag[2] = mag_w(s0.p.first_pz);
  assign s0_mag[3] = mag_w(s0.p.second_px);
  assign s0_mag[4] = mag_w(s0.p.second_py);
  assign s0_mag[5] = mag_w(s0.p.second_pz);
  assign s0_sxm    = mag_s(s0.sx);
  assign s0_sym    = mag_s(s0.sy);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= s0_valid;
    end
    s1 <= s0;
    for (int i = 0; i < 6; i++) begin
      s1_sq[i] <= SQ_W'(s0_mag[i]) * SQ_W'(s0_mag[i]);
    end
    s1_msq[0] <= MSQ_W'(m1_scaled) * MSQ_W'(m1_scaled);
    s1_msq[1] <= MSQ_W'(m2_scaled) * MSQ_W'(m2_scaled);
    s1_sxsq   <= (2*SW)'(s0_sxm) * (2*SW)'(s0_sxm);
    s1_sysq   <= (2*SW)'(s0_sym) * (2*SW)'(s0_sym);
  end

  // ---------------- stage 2: sums of squares ----------------
  front_t           s2;
  logic             s2_valid;
  logic [EIN_W-1:0] s2_sum [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
    s2 <= s1;
    s2_sum[0] <= EIN_W'(s1_msq[0]) + EIN_W'(s1_sq[0]) + EIN_W'(s1_sq[1]) + EIN_W'(s1_sq[2]);
    s2_sum[1] <= EIN_W'(s1_msq[1]) + EIN_W'(s1_sq[3]) + EIN_W'(s1_sq[4]) + EIN_W'(s1_sq[5]);
    s2_sum[2] <= EIN_W'(s1_sxsq) + EIN_W'(s1_sysq);
  end

  // ---------------- energy and pt roots ----------------
  logic            r1_valid;
  logic [H1-1:0]   r1_root [3];
  logic [H1+1:0]   r1_rem  [3];
  front_t          r1_tag;

  plmt_sqrt #(
    .IN_WIDTH  (EIN_W),
    .LANES     (3),
    .TAG_WIDTH ($bits(front_t))
  ) u_sqrt_e (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s2_valid),
    .in_value  (s2_sum),
    .in_tag    (s2),
    .out_valid (r1_valid),
    .out_root  (r1_root),
    .out_rem   (r1_rem),
    .out_tag   (r1_tag)
  );

  // ---------------- stage 3: round roots, total energy ----------------
  front_t          s3;
  logic            s3_valid;
  logic [EBW-1:0]  s3_e1;
  logic [EBW-1:0]  s3_e2;
  logic [PTW-1:0]  s3_pt;
  logic [ETW-1:0]  s3_etot;
  logic [EBW-1:0]  e1_c;
  logic [EBW-1:0]  e2_c;

  // Energies round up, pt rounds to nearest
  assign e1_c = EBW'(r1_root[0]) + EBW'(r1_rem[0] != '0);
  assign e2_c = EBW'(r1_root[1]) + EBW'(r1_rem[1] != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= r1_valid;
    end
    s3      <= r1_tag;
    s3_e1   <= e1_c;
    s3_e2   <= e2_c;
    s3_pt   <= PTW'(r1_root[2]) + PTW'(r1_rem[2] > (H1+2)'(r1_root[2]));
    s3_etot <= ETW'(e1_c) + ETW'(e2_c);
  end

  // ---------------- stage 4: products ----------------
  tail_t                 s4_tl;
  logic                  s4_valid;
  logic [PTW-1:0]        s4_pt;
  logic signed [PRW-1:0] s4_rp [8];
  logic [LSQ_W-1:0]      s4_ee;
  logic signed [2*SW-1:0] s4_zz;
  logic signed [BPW-1:0] s4_ez1;
  logic signed [BPW-1:0] s4_ez2;
  logic signed [BPW-1:0] s4_se1;
  logic signed [BPW-1:0] s4_se2;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else begin
      s4_valid <= s3_valid;
    end
    s4_tl.p    <= s3.p;
    s4_tl.fail <= s3.fail;
    s4_pt      <= s3_pt;
    s4_rp[0]   <= s3.p.first_px * s3.sx;
    s4_rp[1]   <= s3.p.first_py * s3.sy;
    s4_rp[2]   <= s3.p.first_py * s3.sx;
    s4_rp[3]   <= s3.p.first_px * s3.sy;
    s4_rp[4]   <= s3.p.second_px * s3.sx;
    s4_rp[5]   <= s3.p.second_py * s3.sy;
    s4_rp[6]   <= s3.p.second_py * s3.sx;
    s4_rp[7]   <= s3.p.second_px * s3.sy;
    s4_ee      <= LSQ_W'(s3_etot) * LSQ_W'(s3_etot);
    s4_zz      <= s3.sz * s3.sz;
    s4_ez1     <= $signed({1'b0, s3_etot}) * s3.p.first_pz;
    s4_ez2     <= $signed({1'b0, s3_etot}) * s3.p.second_pz;
    s4_se1     <= s3.sz * $signed({1'b0, s3_e1});
    s4_se2     <= s3.sz * $signed({1'b0, s3_e2});
  end

  // ---------------- stage 5: numerators, boost radicand ----------------
  mid_t             s5;
  logic             s5_valid;
  logic [LSQ_W-1:0] s5_lsq [1];
  logic [LSQ_W-1:0] zz_u;

  assign zz_u = LSQ_W'($unsigned(s4_zz));

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_valid <= 1'b0;
    end else begin
      s5_valid <= s4_valid;
    end
    s5.tl     <= s4_tl;
    s5.pt     <= s4_pt;
    s5.rot_x1 <= RSW'(s4_rp[0]) + RSW'(s4_rp[1]);
    s5.rot_y1 <= RSW'(s4_rp[2]) - RSW'(s4_rp[3]);
    s5.rot_x2 <= RSW'(s4_rp[4]) + RSW'(s4_rp[5]);
    s5.rot_y2 <= RSW'(s4_rp[6]) - RSW'(s4_rp[7]);
    s5.bz1    <= BSW'(s4_ez1) - BSW'(s4_se1);
    s5.bz2    <= BSW'(s4_ez2) - BSW'(s4_se2);
    // Fall back to one when the radicand is not positive
    s5_lsq[0] <= (s4_ee > zz_u) ? s4_ee - zz_u : LSQ_W'(1);
  end

  // ---------------- boost denominator root ----------------
  logic            r2_valid;
  logic [ETW-1:0]  r2_root [1];
  logic [ETW+1:0]  r2_rem  [1];
  mid_t            r2_tag;

  plmt_sqrt #(
    .IN_WIDTH  (LSQ_W),
    .LANES     (1),
    .TAG_WIDTH ($bits(mid_t))
  ) u_sqrt_l (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s5_valid),
    .in_value  (s5_lsq),
    .in_tag    (s5),
    .out_valid (r2_valid),
    .out_root  (r2_root),
    .out_rem   (r2_rem),
    .out_tag   (r2_tag)
  );

  // ---------------- stage 6: round boost denominator ----------------
  mid_t           s6;
  logic           s6_valid;
  logic [LW-1:0]  s6_l;

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_valid <= 1'b0;
    end else begin
      s6_valid <= r2_valid;
    end
    s6   <= r2_tag;
    s6_l <= LW'(r2_root[0]) + LW'(r2_rem[0] > (ETW+2)'(r2_root[0]));
  end

  // ---------------- divisions ----------------
  logic signed [BSW-1:0] div_num [6];
  logic [LW-1:0]         div_den [6];
  logic                  dv_valid;
  logic [W-1:0]          dv_quot [6];
  logic                  dv_neg  [6];
  logic                  dv_ovf  [6];
  tail_t                 dv_tag;

  // Lanes: x1, y1, x2, y2 by pt; z1, z2 by the boost denominator
  assign div_num[0] = BSW'(s6.rot_x1);
  assign div_num[1] = BSW'(s6.rot_y1);
  assign div_num[2] = BSW'(s6.rot_x2);
  assign div_num[3] = BSW'(s6.rot_y2);
  assign div_num[4] = s6.bz1;
  assign div_num[5] = s6.bz2;
  assign div_den[0] = LW'(s6.pt);
  assign div_den[1] = LW'(s6.pt);
  assign div_den[2] = LW'(s6.pt);
  assign div_den[3] = LW'(s6.pt);
  assign div_den[4] = s6_l;
  assign div_den[5] = s6_l;

  plmt_div #(
    .QUOT_WIDTH (W),
    .NUM_WIDTH  (BSW),
    .DEN_WIDTH  (LW),
    .LANES      (6),
    .TAG_WIDTH  ($bits(tail_t))
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s6_valid),
    .in_num    (div_num),
    .in_den    (div_den),
    .in_tag    (s6.tl),
    .out_valid (dv_valid),
    .out_quot  (dv_quot),
    .out_neg   (dv_neg),
    .out_ovf   (dv_ovf),
    .out_tag   (dv_tag)
  );

  // ---------------- output register ----------------
  pair_out_t result_next;

  always_comb begin
    if (dv_tag.fail) begin
      // Pass the momenta through unchanged
      result_next.out_first_px  = dv_tag.p.first_px;
      result_next.out_first_py  = dv_tag.p.first_py;
      result_next.out_first_pz  = dv_tag.p.first_pz;
      result_next.out_second_px = dv_tag.p.second_px;
      result_next.out_second_py = dv_tag.p.second_py;
      result_next.out_second_pz = dv_tag.p.second_pz;
    end else begin
      result_next.out_first_px  = saturate(dv_quot[0], dv_neg[0], dv_ovf[0]);
      result_next.out_first_py  = saturate(dv_quot[1], dv_neg[1], dv_ovf[1]);
      result_next.out_second_px = saturate(dv_quot[2], dv_neg[2], dv_ovf[2]);
      result_next.out_second_py = saturate(dv_quot[3], dv_neg[3], dv_ovf[3]);
      result_next.out_first_pz  = saturate(dv_quot[4], dv_neg[4], dv_ovf[4]);
      result_next.out_second_pz = saturate(dv_quot[5], dv_neg[5], dv_ovf[5]);
    end
    result_next.transform_failed = dv_tag.fail;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dv_valid;
    end
    result <= result_next;
  end

endmodule

// ===== tb/sv/tb.sv =====
// Testbench of the pair momentum transform unit: random and directed pairs checked against a predictor.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import plmt_pkg::*;

  localparam int MW = MOMENTUM_WIDTH;
  localparam int LATENCY = 85;

  typedef logic [127:0] u128_t;
  typedef logic signed [127:0] s128_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  pair_in_t pair = '0;
  logic done;
  pair_out_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
  logic [MASS_WIDTH-1:0] cfg_data = '0;

  logic [MASS_WIDTH-1:0] mass_first_q = MASS_RESET;
  logic [MASS_WIDTH-1:0] mass_second_q = MASS_RESET;

  pair_in_t pending_pairs[$];
  pair_out_t expected_results[$];
  int errors = 0;
  int gap_left = 0;
  int accepted = 0;
  bit burst = 1'b0;

  pair_lcms_momentum_transform_unit i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .pair(pair),
    .done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Floor square root of a 128-bit value.
  function automatic logic [63:0] sqrt_floor(u128_t v);
    logic [63:0] r;
    logic [63:0] c;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if (u128_t'(c) * u128_t'(c) <= v) r = c;
    end
    return r;
  endfunction

  function automatic logic [63:0] sqrt_nearest(u128_t v);
    logic [63:0] r;
    r = sqrt_floor(v);
    if (v - u128_t'(r) * u128_t'(r) > u128_t'(r)) r = r + 1;
    return r;
  endfunction

  // Energy rounded up from mass and momentum components.
  function automatic logic [63:0] particle_energy(logic [MASS_WIDTH-1:0] m,
                                                  s128_t x, s128_t y, s128_t z);
    u128_t s;
    logic [63:0] r;
    s = u128_t'(m) * u128_t'(m) + u128_t'(x * x) + u128_t'(y * y) + u128_t'(z * z);
    r = sqrt_floor(s);
    if (u128_t'(r) * u128_t'(r) < s) r = r + 1;
    return r;
  endfunction

  // Divide with rounding half away from zero, then clamp to the momentum range.
  function automatic logic [MW-1:0] round_div(s128_t num, logic [63:0] den);
    logic neg;
    u128_t mag;
    u128_t q;
    u128_t limit;
    u128_t d;
    neg = num < 0;
    mag = neg ? u128_t'(-num) : u128_t'(num);
    d = (den == 0) ? 128'd1 : u128_t'(den);
    q = (2 * mag + d) / (2 * d);
    limit = neg ? (128'd1 << (MW - 1)) : ((128'd1 << (MW - 1)) - 1);
    if (q > limit) q = limit;
    return neg ? MW'(-q) : MW'(q);
  endfunction

  function automatic pair_out_t predict_transform(pair_in_t p);
    pair_out_t o;
    s128_t x1, y1, z1, x2, y2, z2, sx, sy, sz;
    logic [63:0] e1, e2, pt, lden;
    s128_t e12;
    u128_t ee, zz;
    x1 = p.first_px; y1 = p.first_py; z1 = p.first_pz;
    x2 = p.second_px; y2 = p.second_py; z2 = p.second_pz;
    sx = x1 + x2; sy = y1 + y2; sz = z1 + z2;
    // Zero pair pt: pass momenta through and flag
    if (sx == 0 && sy == 0) begin
      o = {p, 1'b1};
      return o;
    end
    e1 = particle_energy(mass_first_q, x1, y1, z1);
    e2 = particle_energy(mass_second_q, x2, y2, z2);
    pt = sqrt_nearest(u128_t'(sx * sx + sy * sy));
    o.out_first_px = round_div(x1 * sx + y1 * sy, pt);
    o.out_first_py = round_div(y1 * sx - x1 * sy, pt);
    o.out_second_px = round_div(x2 * sx + y2 * sy, pt);
    o.out_second_py = round_div(y2 * sx - x2 * sy, pt);
    e12 = s128_t'(e1) + s128_t'(e2);
    ee = u128_t'(e12 * e12);
    zz = u128_t'(sz * sz);
    lden = sqrt_nearest(ee > zz ? ee - zz : 128'd1);
    o.out_first_pz = round_div(e12 * z1 - sz * s128_t'(e1), lden);
    o.out_second_pz = round_div(e12 * z2 - sz * s128_t'(e2), lden);
    o.transform_failed = 1'b0;
    return o;
  endfunction

  // Drive requests from the pending queue with random gaps.
  always @(posedge clk) begin
    logic go;
    if (rst) begin
      start <= 1'b0;
      gap_left = 0;
    end else begin
      go = start;
      if (start && !busy) begin
        expected_results.push_back(predict_transform(pair));
        accepted++;
        if (accepted % 64 == 0) burst = ($urandom_range(0, 2) == 0);
        gap_left = burst ? 0 : $urandom_range(0, 11);
        go = 1'b0;
      end
      if (!go) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_pairs.size() > 0) begin
          pair <= pending_pairs.pop_front();
          go = 1'b1;
        end
      end
      start <= go;
    end
  end

  function automatic void check_field(string name, logic [MW-1:0] exp_v, logic [MW-1:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, got %0d", name, $signed(exp_v), $signed(act_v));
      errors++;
    end
  endfunction

  // Compare each result with the oldest expectation.
  always @(posedge clk) begin
    pair_out_t e;
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result");
        errors++;
      end else begin
        e = expected_results.pop_front();
        check_field("out_first_px", e.out_first_px, result.out_first_px);
        check_field("out_first_py", e.out_first_py, result.out_first_py);
        check_field("out_first_pz", e.out_first_pz, result.out_first_pz);
        check_field("out_second_px", e.out_second_px, result.out_second_px);
        check_field("out_second_py", e.out_second_py, result.out_second_py);
        check_field("out_second_pz", e.out_second_pz, result.out_second_pz);
        if (e.transform_failed !== result.transform_failed) begin
          $error("transform_failed: expected %0d, got %0d", e.transform_failed,
                 result.transform_failed);
          errors++;
        end
      end
    end
  end

  task automatic write_mass(logic [CFG_INDEX_WIDTH-1:0] idx, logic [MASS_WIDTH-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_MASS_FIRST) mass_first_q = val;
    else if (idx == REG_MASS_SECOND) mass_second_q = val;
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (pending_pairs.size() > 0 || expected_results.size() > 0 || start)
      @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  function automatic logic signed [MW-1:0] rand_momentum();
    case ($urandom_range(0, 3))
      0: return MW'($urandom);
      1: return MW'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
      2: return MW'($signed($urandom_range(0, 1 << 12)) - (1 << 11));
      default: return $urandom_range(0, 1) ? {1'b0, {(MW-1){1'b1}}} : {1'b1, {(MW-1){1'b0}}};
    endcase
  endfunction

  function automatic pair_in_t rand_pair();
    pair_in_t p;
    p.first_px = rand_momentum(); p.first_py = rand_momentum();
    p.first_pz = rand_momentum(); p.second_px = rand_momentum();
    p.second_py = rand_momentum(); p.second_pz = rand_momentum();
    // Cancel transverse momentum now and then
    if ($urandom_range(0, 9) == 0) begin
      p.second_px = -p.first_px;
      p.second_py = -p.first_py;
    end
    return p;
  endfunction

  localparam logic signed [MW-1:0] PMAX = {1'b0, {(MW-1){1'b1}}};
  localparam logic signed [MW-1:0] PMIN = {1'b1, {(MW-1){1'b0}}};

  initial begin
    pair_in_t p;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed pairs at reset masses
    pending_pairs.push_back('0);
    pending_pairs.push_back('{5, -7, 100, -5, 7, -3});
    pending_pairs.push_back('{PMIN, PMIN, PMIN, PMIN, PMIN, PMIN});
    pending_pairs.push_back('{PMAX, PMAX, PMAX, PMAX, PMAX, PMAX});
    pending_pairs.push_back('{PMAX, PMIN, PMAX, PMIN, PMAX, PMIN});
    pending_pairs.push_back('{PMIN, 0, 0, PMIN, 0, 0});
    pending_pairs.push_back('{1, 0, 0, 0, 0, 0});
    pending_pairs.push_back('{0, -1, 0, 0, 0, 0});
    pending_pairs.push_back('{1, 0, PMAX, 0, 0, PMAX});
    pending_pairs.push_back('{65536, 0, PMIN, 0, 65536, PMIN});
    pending_pairs.push_back('{PMAX, 0, 0, PMIN, 1, 0});
    pending_pairs.push_back('{-1, -1, -1, -1, -1, -1});
    pending_pairs.push_back('{PMIN, PMAX, 0, PMAX, PMIN, 0});
    pending_pairs.push_back('{100, 200, 300, -400, 500, -600});
    drain();

    // Random phases across mass settings, extremes included
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: ;
        1: begin
          write_mass(REG_MASS_FIRST, '0);
          write_mass(REG_MASS_SECOND, '0);
        end
        2: begin
          write_mass(REG_MASS_FIRST, '1);
          write_mass(REG_MASS_SECOND, '1);
        end
        3: begin
          write_mass(REG_MASS_FIRST, '0);
          write_mass(REG_MASS_SECOND, '1);
          write_mass(CFG_INDEX_WIDTH'(2), MASS_WIDTH'($urandom));
          write_mass('1, MASS_WIDTH'($urandom));
        end
        default: begin
          write_mass(REG_MASS_FIRST, MASS_WIDTH'($urandom));
          write_mass(REG_MASS_SECOND, MASS_WIDTH'($urandom));
        end
      endcase
      for (int n = 0; n < 185; n++) begin
        p = rand_pair();
        pending_pairs.push_back(p);
      end
      drain();
    end

    if (errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  // Hold the run to a fixed time budget.
  initial begin
    #5ms;
    $display("tb: FAIL");
    $finish;
  end

endmodule
